// File: rtl/core/psdc_pkg.sv
// Shared constants, types and helper functions for the port-mapped sector disk controller.
// Used by the memory modules and the top level; depends on nothing else.
`default_nettype none

package psdc_pkg;

    localparam int DRIVES        = 4;
    localparam int DRV_W         = 2;
    localparam int SECTOR_BYTES  = 128;
    localparam int BYTE_W        = 7;
    localparam int IMAGE_SECTORS = 2048;
    localparam int SEC_W         = 11;
    localparam int LIMIT_W       = 12;
    localparam int IDX_W         = 8;
    localparam int LIN_W         = 17;

    localparam int STORE_AW      = DRV_W + SEC_W + BYTE_W;
    localparam int BUF_AW        = DRV_W + BYTE_W;
    localparam int TAG_BIT_W     = 5;
    localparam int TAG_ROW_BITS  = 1 << TAG_BIT_W;
    localparam int TAG_AW        = DRV_W + SEC_W - TAG_BIT_W;
    localparam int CLR_W         = BUF_AW;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;
    localparam int READY_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SPT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMG0       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMG1       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMG2       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMG3       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT     = 3'd5;

    localparam logic [7:0] SPT_RESET      = 8'd26;
    localparam logic [7:0] SELECT_RESET   = 8'd227;

    localparam logic [7:0] PORT_DATA      = 8'hE0;
    localparam logic [7:0] PORT_TRACK     = 8'hE1;
    localparam logic [7:0] PORT_SECTOR    = 8'hE2;

    localparam logic       ACC_WRITE      = 1'b0;
    localparam logic       ACC_READ       = 1'b1;

    localparam logic [7:0] DCMD_LOAD      = 8'h00;
    localparam logic [7:0] DCMD_SAVE      = 8'h01;
    localparam logic [7:0] NOT_READY_BYTE = 8'hFF;

    localparam logic [IDX_W-1:0]   SECTOR_BYTES_I = IDX_W'(SECTOR_BYTES);
    localparam logic [7:0]         DRIVES_B       = 8'(DRIVES);
    localparam logic [LIMIT_W-1:0] IMAGE_LIMIT    = LIMIT_W'(IMAGE_SECTORS);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } t_store_req;

    typedef struct packed {
        logic                    rd_en;
        logic                    wr_en;
        logic [TAG_AW-1:0]       row;
        logic [TAG_ROW_BITS-1:0] wdata;
    } t_tag_req;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_buf_req;

    function automatic logic [LIMIT_W-1:0] limit_of(input logic [LIMIT_W-1:0] size);
        return (size > IMAGE_LIMIT) ? IMAGE_LIMIT : size;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/port_mapped_sector_disk_controller.sv
// Top level of the port-mapped sector disk controller: port decode, per-drive registers,
// sector copy sequencer and output register. Uses psdc_pkg, psdc_buf_mem and psdc_store_mem.
// Steps: a register access goes through decode and output; a data byte read adds a buffer
// read; a sector load or commit adds the locate state and the one-byte-per-cycle copy loop.
// Throughput: one transaction at a time; the next is accepted once the result is registered.
// Reset: synchronous, active low; afterwards a clearing pass of the buffers and sector
// tags runs, during which no transaction is accepted but configuration writes are.
`default_nettype none

module port_mapped_sector_disk_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_port,
    input  wire logic [7:0]  i_data,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data,
    output logic [1:0]       o_current_drive,
    output logic [7:0]       o_current_track,
    output logic [7:0]       o_current_sector,
    output logic [2:0]       o_ready_drives
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_LOCATE = 8'b0000_1000,
        S_LOAD   = 8'b0001_0000,
        S_COMMIT = 8'b0010_0000,
        S_BUFRD  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    localparam int DRV_N = psdc_pkg::DRIVES;
    localparam int IW    = psdc_pkg::IDX_W;

    t_state r_state, n_state;

    logic [7:0]                    r_spt;
    logic [psdc_pkg::LIMIT_W-1:0]  r_img [DRV_N];
    logic [7:0]                    r_sel_port;

    logic                          r_cmd;
    logic [7:0]                    r_port;
    logic [7:0]                    r_data;

    logic [psdc_pkg::DRV_W-1:0]    r_sel, n_sel;
    logic [7:0]                    r_track [DRV_N], n_track [DRV_N];
    logic [7:0]                    r_sector [DRV_N], n_sector [DRV_N];
    logic [IW-1:0]                 r_idx [DRV_N], n_idx [DRV_N];
    psdc_pkg::t_mode               r_mode [DRV_N], n_mode [DRV_N];
    logic                          r_err [DRV_N], n_err [DRV_N];

    logic                          r_is_load, n_is_load;
    logic [psdc_pkg::SEC_W-1:0]    r_sidx, n_sidx;
    logic [IW-1:0]                 r_cnt, n_cnt;
    logic [psdc_pkg::CLR_W-1:0]    r_clr, n_clr;
    logic [7:0]                    r_rd, n_rd;
    logic                          r_out_valid, n_out_valid;

    logic [7:0]                    r_o_rd;
    logic [psdc_pkg::DRV_W-1:0]    r_o_drive;
    logic [7:0]                    r_o_track;
    logic [7:0]                    r_o_sector;
    logic [psdc_pkg::READY_W-1:0]  r_o_ready;

    psdc_pkg::t_buf_req            buf_req;
    psdc_pkg::t_store_req          store_req;
    psdc_pkg::t_tag_req            tag_req;
    logic [7:0]                    buf_q;
    logic [7:0]                    store_q;
    logic [psdc_pkg::TAG_ROW_BITS-1:0] tag_q;

    logic [psdc_pkg::LIMIT_W-1:0]  lim;
    logic [psdc_pkg::LIN_W-1:0]    lin;
    logic                          in_range;
    logic [IW-1:0]                 idx_next;
    logic [psdc_pkg::DRV_W+psdc_pkg::SEC_W-1:0] tag_addr_new;
    logic [psdc_pkg::DRV_W+psdc_pkg::SEC_W-1:0] tag_addr_cur;
    logic                          tag_hit;
    logic [IW-1:0]                 cnt_prev;
    logic                          load_out;
    logic [psdc_pkg::READY_W-1:0]  ready_cnt;

    psdc_buf_mem u_buf (
        .i_clk   (i_clk),
        .i_req   (buf_req),
        .o_rdata (buf_q)
    );

    psdc_store_mem u_store (
        .i_clk         (i_clk),
        .i_store       (store_req),
        .i_tag         (tag_req),
        .o_store_rdata (store_q),
        .o_tag_rdata   (tag_q)
    );

    assign lim          = psdc_pkg::limit_of(r_img[r_sel]);
    assign lin          = psdc_pkg::LIN_W'(r_track[r_sel]) * psdc_pkg::LIN_W'(r_spt)
                          + psdc_pkg::LIN_W'(r_sector[r_sel]);
    assign in_range     = lin < psdc_pkg::LIN_W'(lim);
    assign idx_next     = r_idx[r_sel] + IW'(1);
    assign tag_addr_new = {r_sel, lin[psdc_pkg::SEC_W-1:0]};
    assign tag_addr_cur = {r_sel, r_sidx};
    assign tag_hit      = tag_q[tag_addr_cur[psdc_pkg::TAG_BIT_W-1:0]];
    assign cnt_prev     = r_cnt - IW'(1);
    assign load_out     = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        ready_cnt = '0;
        for (int k = 0; k < DRV_N; k++) begin
            ready_cnt = ready_cnt + psdc_pkg::READY_W'(r_img[k] != '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_track     = r_track;
        n_sector    = r_sector;
        n_idx       = r_idx;
        n_mode      = r_mode;
        n_err       = r_err;
        n_is_load   = r_is_load;
        n_sidx      = r_sidx;
        n_cnt       = r_cnt;
        n_clr       = r_clr;
        n_rd        = r_rd;
        n_out_valid = r_out_valid;
        buf_req     = '0;
        store_req   = '0;
        tag_req     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                buf_req.wr_en = 1'b1;
                buf_req.addr  = r_clr;
                tag_req.wr_en = 1'b1;
                tag_req.row   = r_clr[psdc_pkg::TAG_AW-1:0];
                n_clr         = r_clr + psdc_pkg::CLR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_rd    = '0;
                n_state = S_OUT;
                if (r_cmd == psdc_pkg::ACC_WRITE) begin
                    priority if (r_port == r_sel_port) begin
                        if (r_data < psdc_pkg::DRIVES_B) begin
                            n_sel = r_data[psdc_pkg::DRV_W-1:0];
                        end
                    end else if (lim == '0) begin
                        n_state = S_OUT;
                    end else if (r_port == psdc_pkg::PORT_TRACK) begin
                        n_track[r_sel] = r_data;
                    end else if (r_port == psdc_pkg::PORT_SECTOR) begin
                        n_sector[r_sel] = r_data;
                    end else if (r_port == psdc_pkg::PORT_DATA) begin
                        priority if (r_mode[r_sel] == psdc_pkg::MODE_IDLE) begin
                            if (r_data == psdc_pkg::DCMD_LOAD) begin
                                n_mode[r_sel] = psdc_pkg::MODE_READ;
                                n_idx[r_sel]  = '0;
                                n_is_load     = 1'b1;
                                n_state       = S_LOCATE;
                            end else if (r_data == psdc_pkg::DCMD_SAVE) begin
                                n_mode[r_sel] = psdc_pkg::MODE_WRITE;
                                n_idx[r_sel]  = '0;
                                n_err[r_sel]  = 1'b0;
                            end
                        end else if (r_mode[r_sel] == psdc_pkg::MODE_WRITE) begin
                            if (r_idx[r_sel] < psdc_pkg::SECTOR_BYTES_I) begin
                                buf_req.wr_en = 1'b1;
                                buf_req.addr  = {r_sel, r_idx[r_sel][psdc_pkg::BYTE_W-1:0]};
                                buf_req.wdata = r_data;
                                n_idx[r_sel]  = idx_next;
                                if (idx_next >= psdc_pkg::SECTOR_BYTES_I) begin
                                    n_mode[r_sel] = psdc_pkg::MODE_IDLE;
                                    n_is_load     = 1'b0;
                                    n_state       = S_LOCATE;
                                end
                            end else begin
                                n_mode[r_sel] = psdc_pkg::MODE_IDLE;
                                n_is_load     = 1'b0;
                                n_state       = S_LOCATE;
                            end
                        end else begin
                        end
                    end else begin
                    end
                end else begin
                    priority if (lim == '0) begin
                        n_rd = psdc_pkg::NOT_READY_BYTE;
                    end else if (r_port == psdc_pkg::PORT_SECTOR) begin
                        n_rd = {7'd0, r_err[r_sel]};
                    end else if (r_port == psdc_pkg::PORT_DATA
                                 && r_mode[r_sel] == psdc_pkg::MODE_READ
                                 && r_idx[r_sel] < psdc_pkg::SECTOR_BYTES_I) begin
                        buf_req.rd_en = 1'b1;
                        buf_req.addr  = {r_sel, r_idx[r_sel][psdc_pkg::BYTE_W-1:0]};
                        n_idx[r_sel]  = idx_next;
                        if (idx_next >= psdc_pkg::SECTOR_BYTES_I) begin
                            n_mode[r_sel] = psdc_pkg::MODE_IDLE;
                        end
                        n_state = S_BUFRD;
                    end else begin
                    end
                end
            end
            S_LOCATE: begin
                n_err[r_sel] = !in_range;
                n_sidx       = lin[psdc_pkg::SEC_W-1:0];
                n_cnt        = '0;
                if (in_range) begin
                    tag_req.rd_en = 1'b1;
                    tag_req.row   = tag_addr_new[psdc_pkg::DRV_W+psdc_pkg::SEC_W-1:
                                                 psdc_pkg::TAG_BIT_W];
                    n_state       = r_is_load ? S_LOAD : S_COMMIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LOAD: begin
                if (r_cnt < psdc_pkg::SECTOR_BYTES_I) begin
                    store_req.rd_en = 1'b1;
                    store_req.addr  = {r_sel, r_sidx, r_cnt[psdc_pkg::BYTE_W-1:0]};
                end
                if (r_cnt != '0) begin
                    buf_req.wr_en = 1'b1;
                    buf_req.addr  = {r_sel, cnt_prev[psdc_pkg::BYTE_W-1:0]};
                    buf_req.wdata = tag_hit ? store_q : 8'd0;
                end
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == psdc_pkg::SECTOR_BYTES_I) begin
                    n_state = S_OUT;
                end
            end
            S_COMMIT: begin
                if (r_cnt < psdc_pkg::SECTOR_BYTES_I) begin
                    buf_req.rd_en = 1'b1;
                    buf_req.addr  = {r_sel, r_cnt[psdc_pkg::BYTE_W-1:0]};
                end
                if (r_cnt != '0) begin
                    store_req.wr_en = 1'b1;
                    store_req.addr  = {r_sel, r_sidx, cnt_prev[psdc_pkg::BYTE_W-1:0]};
                    store_req.wdata = buf_q;
                end
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == psdc_pkg::SECTOR_BYTES_I) begin
                    tag_req.wr_en = 1'b1;
                    tag_req.row   = tag_addr_cur[psdc_pkg::DRV_W+psdc_pkg::SEC_W-1:
                                                 psdc_pkg::TAG_BIT_W];
                    tag_req.wdata = tag_q | (psdc_pkg::TAG_ROW_BITS'(1)
                                    << tag_addr_cur[psdc_pkg::TAG_BIT_W-1:0]);
                    n_state       = S_OUT;
                end
            end
            S_BUFRD: begin
                n_rd    = buf_q;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
            r_is_load   <= 1'b0;
            r_cnt       <= '0;
            for (int k = 0; k < DRV_N; k++) begin
                r_track[k]  <= '0;
                r_sector[k] <= '0;
                r_idx[k]    <= '0;
                r_mode[k]   <= psdc_pkg::MODE_IDLE;
                r_err[k]    <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
            r_is_load   <= n_is_load;
            r_cnt       <= n_cnt;
            r_track     <= n_track;
            r_sector    <= n_sector;
            r_idx       <= n_idx;
            r_mode      <= n_mode;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt      <= psdc_pkg::SPT_RESET;
            r_sel_port <= psdc_pkg::SELECT_RESET;
            for (int k = 0; k < DRV_N; k++) begin
                r_img[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psdc_pkg::REG_SPT:    r_spt      <= i_cfg_data[7:0];
                psdc_pkg::REG_IMG0:   r_img[0]   <= i_cfg_data;
                psdc_pkg::REG_IMG1:   r_img[1]   <= i_cfg_data;
                psdc_pkg::REG_IMG2:   r_img[2]   <= i_cfg_data;
                psdc_pkg::REG_IMG3:   r_img[3]   <= i_cfg_data;
                psdc_pkg::REG_SELECT: r_sel_port <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sidx <= n_sidx;
        r_rd   <= n_rd;
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd  <= i_cmd;
            r_port <= i_port;
            r_data <= i_data;
        end
        if (load_out) begin
            r_o_rd     <= r_rd;
            r_o_drive  <= r_sel;
            r_o_track  <= r_track[r_sel];
            r_o_sector <= r_sector[r_sel];
            r_o_ready  <= ready_cnt;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_o_rd;
    assign o_current_drive  = r_o_drive;
    assign o_current_track  = r_o_track;
    assign o_current_sector = r_o_sector;
    assign o_ready_drives   = r_o_ready;

endmodule

`default_nettype wire

// File: rtl/core/psdc_buf_mem.sv
// Sector buffer memory: one 128-byte buffer per drive, one port with a shared address for writes and registered reads.
// Depends on psdc_pkg.
`default_nettype none

module psdc_buf_mem (
    input  wire logic                i_clk,
    input  wire psdc_pkg::t_buf_req  i_req,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [2**psdc_pkg::BUF_AW];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// File: rtl/core/psdc_store_mem.sv
// Image store of all drives plus a written-sector tag memory that stands in for clearing it.
// Depends on psdc_pkg.
`default_nettype none

module psdc_store_mem (
    input  wire logic                  i_clk,
    input  wire psdc_pkg::t_store_req  i_store,
    input  wire psdc_pkg::t_tag_req    i_tag,
    output logic [7:0]                 o_store_rdata,
    output logic [psdc_pkg::TAG_ROW_BITS-1:0] o_tag_rdata
);

    logic [7:0]                        r_store [2**psdc_pkg::STORE_AW];
    logic [psdc_pkg::TAG_ROW_BITS-1:0] r_tags  [2**psdc_pkg::TAG_AW];
    logic [7:0]                        r_store_q;
    logic [psdc_pkg::TAG_ROW_BITS-1:0] r_tag_q;

    always_ff @(posedge i_clk) begin
        if (i_store.wr_en) begin
            r_store[i_store.addr] <= i_store.wdata;
        end
        if (i_store.rd_en) begin
            r_store_q <= r_store[i_store.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.wr_en) begin
            r_tags[i_tag.row] <= i_tag.wdata;
        end
        if (i_tag.rd_en) begin
            r_tag_q <= r_tags[i_tag.row];
        end
    end

    assign o_store_rdata = r_store_q;
    assign o_tag_rdata   = r_tag_q;

endmodule

`default_nettype wire
